>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the range selector
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset
`define SARS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sars assertion failed");
// Condition that must never be seen outside reset
`define SARS_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("sars forbidden condition seen");
`else
`define SARS_ASSERT(lbl, clk, rst, prop)
`define SARS_NEVER(lbl, clk, rst, cond)
`endif
`endif

>>> rtl/sars_pkg.sv
// Package of the sensor auto-range selector: widths, codes, types
package sars_pkg;

  localparam int READING_W   = 12;
  localparam int IDX_W       = 3;
  localparam int ERR_W       = 7;
  localparam int WORD_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int ENTRY_REGS  = 5;
  localparam int NUM_RANGES_DEF = 5;
  localparam int NUM_RANGES_MAX = 6;

  localparam logic [BYTE_W-1:0] ERR_BYTE_MAX = 8'd127;
  localparam logic [ERR_W-1:0]  ERR_INVALID = ERR_BYTE_MAX[ERR_W-1:0];
  localparam logic [WORD_W-1:0] ENTRY_RESET = 32'h7F00_0000;
  localparam logic [BYTE_W-1:0] MARGIN_RESET = 8'd16;
  localparam logic [BYTE_W-1:0] HOLD_RESET   = 8'd4;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_ENTRY_0       = 3'd0,
    REG_ENTRY_1       = 3'd1,
    REG_ENTRY_2       = 3'd2,
    REG_ENTRY_3       = 3'd3,
    REG_ENTRY_4       = 3'd4,
    REG_EDGE_MARGIN   = 3'd5,
    REG_HOLD_READINGS = 3'd6
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACTIVE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Global settings from the register bank
  typedef struct packed {
    logic [BYTE_W-1:0] edge_margin;
    logic [BYTE_W-1:0] hold_readings;
  } settings_t;

  // Verdict of the shared fit unit on one table entry
  typedef struct packed {
    logic             fits;
    logic [ERR_W-1:0] err;
  } fit_t;

endpackage

>>> rtl/sars_if.sv
// Handshake channel interfaces: readings in, results out, register writes

interface sars_in_if;
  import sars_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [READING_W-1:0] reading;
  modport source (output valid, output reading, input ready);
  modport sink   (input valid, input reading, output ready);
endinterface

interface sars_out_if;
  import sars_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] range_used;
  logic [ERR_W-1:0] error_bound;
  logic [IDX_W-1:0] chosen_range;
  logic [IDX_W-1:0] next_range;
  logic             switched;
  logic             out_of_range;
  modport source (output valid, output range_used, output error_bound,
                  output chosen_range, output next_range, output switched,
                  output out_of_range, input ready);
  modport sink   (input valid, input range_used, input error_bound,
                  input chosen_range, input next_range, input switched,
                  input out_of_range, output ready);
endinterface

interface sars_cfg_if;
  import sars_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [WORD_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/sars_regs.sv
// Configuration register bank with one indexed read port for the range table
module sars_regs (
  input  logic                        clk,
  input  logic                        rst,
  sars_cfg_if.sink                    cfg,
  input  logic [sars_pkg::IDX_W-1:0]  rd_idx,
  output logic [sars_pkg::WORD_W-1:0] rd_word,
  output sars_pkg::settings_t         settings
);
  import sars_pkg::*;

  logic [WORD_W-1:0] entry [ENTRY_REGS];
  logic [BYTE_W-1:0] edge_margin;
  logic [BYTE_W-1:0] hold_readings;

  assign cfg.ready = 1'b1;

  // Take register writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRY_REGS; i++) begin
        entry[i] <= ENTRY_RESET;
      end
      edge_margin   <= MARGIN_RESET;
      hold_readings <= HOLD_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ENTRY_0, REG_ENTRY_1, REG_ENTRY_2, REG_ENTRY_3, REG_ENTRY_4: begin
          entry[cfg.index] <= cfg.data;
        end
        REG_EDGE_MARGIN:   edge_margin   <= cfg.data[BYTE_W-1:0];
        REG_HOLD_READINGS: hold_readings <= cfg.data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Entries past the register list read as the reset word
  always_comb begin
    if (rd_idx < IDX_W'(ENTRY_REGS)) begin
      rd_word = entry[rd_idx];
    end else begin
      rd_word = ENTRY_RESET;
    end
  end

  assign settings.edge_margin   = edge_margin;
  assign settings.hold_readings = hold_readings;

endmodule

>>> rtl/sars_fit.sv
// Shared compare unit: checks a reading against one entry's shrunk bounds
module sars_fit (
  input  logic [sars_pkg::WORD_W-1:0]           word,
  input  logic [sars_pkg::BYTE_W-1:0]           margin,
  input  logic signed [sars_pkg::READING_W-1:0] reading,
  output sars_pkg::fit_t                        fit
);
  import sars_pkg::*;

  localparam int CMP_W = READING_W + 2;

  logic signed [CMP_W-1:0] lo;
  logic signed [CMP_W-1:0] hi;
  logic signed [CMP_W-1:0] rd;
  logic [BYTE_W-1:0]       err_raw;

  // Shrink the bounds by the margin and compare
  always_comb begin
    lo = {{2{word[READING_W-1]}}, word[READING_W-1:0]} + {6'd0, margin};
    hi = {{2{word[2*READING_W-1]}}, word[2*READING_W-1:READING_W]} - {6'd0, margin};
    rd = {{2{reading[READING_W-1]}}, reading};
    fit.fits = (rd >= lo) && (rd <= hi);
  end

  // Saturate the error byte; anything above the limit is invalid
  always_comb begin
    err_raw = word[WORD_W-1:WORD_W-BYTE_W];
    fit.err = (err_raw > ERR_BYTE_MAX) ? ERR_INVALID : err_raw[ERR_W-1:0];
  end

endmodule

>>> rtl/sars_seq.sv
// Sequencer: scans the table through the shared fit unit and decides the range
module sars_seq #(
  parameter int NUM_RANGES = sars_pkg::NUM_RANGES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  sars_in_if.sink                               sample,
  sars_out_if.source                            result,
  input  sars_pkg::settings_t                   settings,
  input  sars_pkg::fit_t                        fit,
  output logic [sars_pkg::IDX_W-1:0]            rd_idx,
  output logic signed [sars_pkg::READING_W-1:0] reading
);
  import sars_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_RANGES - 1);

  state_t            state;
  state_t            state_next;
  logic [IDX_W-1:0]  active_range;
  logic [BYTE_W-1:0] hold_left;
  logic [IDX_W-1:0]  cnt;
  logic [IDX_W-1:0]  best;
  logic [ERR_W-1:0]  best_err;
  logic [ERR_W-1:0]  score;
  logic [ERR_W-1:0]  used_err;
  logic              out_free;

  // Decision terms, worked out in the final step
  logic [BYTE_W-1:0] hold_dec;
  logic              want;
  logic              do_switch;
  logic              oor;

  assign out_free     = !result.valid || result.ready;
  assign sample.ready = (state == ST_IDLE);

  always_comb begin
    hold_dec  = (hold_left != '0) ? hold_left - 8'd1 : hold_left;
    want      = (hold_dec == '0) && (best != active_range);
    oor       = want && (best_err == ERR_INVALID);
    do_switch = want && (best_err != ERR_INVALID);
  end

  // Next state and table read address
  always_comb begin
    state_next = state;
    rd_idx     = cnt;
    unique case (state)
      ST_IDLE: begin
        if (sample.valid) state_next = ST_ACTIVE;
      end
      ST_ACTIVE: begin
        rd_idx     = active_range;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt == LAST_IDX) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan datapath: seed with the active range, then walk the table
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (sample.valid) reading <= sample.reading;
        cnt <= '0;
      end
      ST_ACTIVE: begin
        used_err <= fit.err;
        best     <= active_range;
        best_err <= fit.err;
        score    <= fit.fits ? fit.err : ERR_INVALID;
      end
      ST_SCAN: begin
        if (fit.fits && (fit.err <= score)) begin
          best     <= cnt;
          best_err <= fit.err;
          score    <= fit.err;
        end
        cnt <= cnt + 3'd1;
      end
      default: ;
    endcase
  end

  // Commit the decision and hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      active_range  <= '0;
      hold_left     <= '0;
      result.valid  <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        result.valid <= 1'b1;
        if (do_switch) begin
          active_range <= best;
          hold_left    <= settings.hold_readings;
        end else begin
          hold_left    <= hold_dec;
        end
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      result.range_used     <= active_range;
      result.error_bound    <= used_err;
      result.chosen_range   <= best;
      result.next_range     <= do_switch ? best : active_range;
      result.switched       <= do_switch;
      result.out_of_range   <= oor;
    end
  end

endmodule

>>> rtl/sensor_auto_range_selector_top.sv
// Top level of the sensor auto-range selector
//
// Channels: sample (sink) takes one signed 12-bit reading in sixteenths of
// a degree, taken in the currently active range. result (source) returns one
// item per reading: the range used and its error bound, the best range found,
// the range in force next, and switched / out_of_range flags. cfg takes
// register writes (range table entries, edge margin, hold count) and is
// always ready.
// One fit unit checks one table entry per cycle: one pass for the active range,
// then one per table entry. The block takes one reading at a time, so it takes
// no new reading before the last one has left the final step.
// Reset: synchronous rst restores the table to invalid entries (error 127),
// margin 16, hold count 4, active range 0, hold counter 0.
// A stalled receiver holds the result in the output register; the next
// reading is still accepted and scanned, and waits in the final step until
// the output register is free.
module sensor_auto_range_selector_top #(
  parameter int NUM_RANGES = sars_pkg::NUM_RANGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sars_in_if.sink    sample,
  sars_out_if.source result,
  sars_cfg_if.sink   cfg
);
  import sars_pkg::*;
  `include "assert_macros.svh"

  logic [IDX_W-1:0]            rd_idx;
  logic [WORD_W-1:0]           rd_word;
  logic signed [READING_W-1:0] reading;
  settings_t                   settings;
  fit_t                        fit;

  sars_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .rd_idx   (rd_idx),
    .rd_word  (rd_word),
    .settings (settings)
  );

  sars_fit u_fit (
    .word    (rd_word),
    .margin  (settings.edge_margin),
    .reading (reading),
    .fit     (fit)
  );

  sars_seq #(
    .NUM_RANGES (NUM_RANGES)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .result   (result),
    .settings (settings),
    .fit      (fit),
    .rd_idx   (rd_idx),
    .reading  (reading)
  );

  // A reading keeps the block busy for the cycle after it is taken
  `SARS_ASSERT(a_busy_after_take, clk, rst, (sample.valid && sample.ready) |=> !sample.ready)
  // A switch and an out-of-range flag exclude each other
  `SARS_NEVER(a_sw_oor_excl, clk, rst, result.valid && result.switched && result.out_of_range)
  // The switched flag matches a change of range
  `SARS_ASSERT(a_sw_matches, clk, rst,
    result.valid |-> (result.switched == (result.next_range != result.range_used)))
  // The range in force stays inside the table
  `SARS_ASSERT(a_range_in_table, clk, rst,
    result.valid |-> (result.next_range < IDX_W'(NUM_RANGES)))

endmodule

>>> tb/sensor_auto_range_selector_top_tb.sv
// Testbench of the sensor auto-range selector: predicting scoreboard, stimulus and checks
`timescale 1ns / 1ps

module sensor_auto_range_selector_top_tb;
  import sars_pkg::*;

  localparam int NUM_RANGES    = NUM_RANGES_DEF;
  localparam int LATENCY       = NUM_RANGES + 3;
  localparam int DIRECTED_N    = 24;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 166;
  localparam int READING_MIN   = -2048;
  localparam int READING_MAX   = 2047;
  // Index past the register list; writes there must be ignored
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  // One result item as the block should return it
  typedef struct packed {
    logic [IDX_W-1:0] range_used;
    logic [ERR_W-1:0] error_bound;
    logic [IDX_W-1:0] chosen_range;
    logic [IDX_W-1:0] next_range;
    logic             switched;
    logic             out_of_range;
  } range_verdict_t;

  // Tracks the selector state and the verdicts still owed by the block
  class range_verdict_board;
    logic [WORD_W-1:0] entry [ENTRY_REGS];
    int unsigned       margin;
    int unsigned       hold_reload;
    logic [IDX_W-1:0]  active;
    int unsigned       hold_left;
    range_verdict_t    awaited [$];
    int unsigned       faults;
    int unsigned       shown;

    function new();
      foreach (entry[i]) entry[i] = ENTRY_RESET;
      margin      = int'(MARGIN_RESET);
      hold_reload = int'(HOLD_RESET);
      active      = '0;
      hold_left   = 0;
      faults      = 0;
      shown       = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      case (idx)
        REG_ENTRY_0, REG_ENTRY_1, REG_ENTRY_2, REG_ENTRY_3, REG_ENTRY_4: begin
          entry[idx] = data;
        end
        REG_EDGE_MARGIN: begin
          margin = int'(data[BYTE_W-1:0]);
        end
        REG_HOLD_READINGS: begin
          hold_reload = int'(data[BYTE_W-1:0]);
        end
        default: ;
      endcase
    endfunction

    // Entries past the register bank read as invalid
    function logic [WORD_W-1:0] word_of(int i);
      return (i < ENTRY_REGS) ? entry[i] : ENTRY_RESET;
    endfunction

    // Error byte, saturated to the invalid code
    function logic [ERR_W-1:0] err_of(int i);
      logic [WORD_W-1:0] w;
      logic [BYTE_W-1:0] e;
      w = word_of(i);
      e = w[31:24];
      return (e > ERR_BYTE_MAX) ? ERR_INVALID : e[ERR_W-1:0];
    endfunction

    // Reading inside the bounds shrunk by the margin
    function bit fits(int i, int r);
      logic [WORD_W-1:0] w;
      int lo;
      int hi;
      w  = word_of(i);
      lo = int'($signed(w[11:0])) + int'(margin);
      hi = int'($signed(w[23:12])) - int'(margin);
      return (r >= lo) && (r <= hi);
    endfunction

    // Smallest error among qualifying ranges, later entry wins a tie
    function logic [IDX_W-1:0] select_range(int r);
      logic [IDX_W-1:0] best;
      logic [ERR_W-1:0] score;
      best  = active;
      score = fits(active, r) ? err_of(active) : ERR_INVALID;
      for (int i = 0; i < NUM_RANGES; i++) begin
        if (fits(i, r) && err_of(i) <= score) begin
          best  = i[IDX_W-1:0];
          score = err_of(i);
        end
      end
      return best;
    endfunction

    function void note_reading(logic signed [READING_W-1:0] rd);
      range_verdict_t v;
      int             r;
      logic [IDX_W-1:0] prop;
      r                = rd;
      v.range_used     = active;
      v.error_bound    = err_of(active);
      prop             = select_range(r);
      v.chosen_range   = prop;
      v.switched       = 1'b0;
      v.out_of_range   = 1'b0;
      if (hold_left > 0) hold_left--;
      // Switch only once the hold has run out; an invalid target just flags
      if (hold_left == 0 && prop != active) begin
        if (err_of(prop) == ERR_INVALID) begin
          v.out_of_range = 1'b1;
        end else begin
          active     = prop;
          hold_left  = hold_reload;
          v.switched = 1'b1;
        end
      end
      v.next_range = active;
      awaited.push_back(v);
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report(string msg);
      faults++;
      if (shown < 40) begin
        $display("%0t ns: %s", $time, msg);
        shown++;
      end
    endtask

    task check_verdict(range_verdict_t got);
      range_verdict_t want;
      if (awaited.size() == 0) begin
        report("result item with no reading waiting for it");
        return;
      end
      want = awaited.pop_front();
      if (got.range_used !== want.range_used)
        report($sformatf("range_used got %0d want %0d", got.range_used, want.range_used));
      if (got.error_bound !== want.error_bound)
        report($sformatf("error_bound got %0d want %0d", got.error_bound, want.error_bound));
      if (got.chosen_range !== want.chosen_range)
        report($sformatf("chosen_range got %0d want %0d",
                         got.chosen_range, want.chosen_range));
      if (got.next_range !== want.next_range)
        report($sformatf("next_range got %0d want %0d", got.next_range, want.next_range));
      if (got.switched !== want.switched)
        report($sformatf("switched got %0b want %0b", got.switched, want.switched));
      if (got.out_of_range !== want.out_of_range)
        report($sformatf("out_of_range got %0b want %0b",
                         got.out_of_range, want.out_of_range));
    endtask
  endclass

  logic clk;
  logic rst;

  sars_in_if  sample_ch ();
  sars_out_if result_ch ();
  sars_cfg_if cfg_ch ();

  range_verdict_board board = new();

  int burst_left;
  int stall_mode = 0;
  int stall_seg  = 0;
  int walk_pos;

  int directed_readings [DIRECTED_N] = '{
    0, 0, -1, 1, 384, 385, -384, -385, 105, 1500, 2047, -2048,
    900, 984, 985, 2031, 2032, -2032, -2033, 500, -500, 1500, 0, 2047
  };

  sensor_auto_range_selector_top DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: stall on a pattern that changes mode every segment
  always @(posedge clk) begin
    if (stall_seg == 0) begin
      stall_mode = $urandom_range(3, 0);
      stall_seg  = $urandom_range(200, 20);
    end
    stall_seg--;
    case (stall_mode)
      0: result_ch.ready <= 1'b1;
      1: result_ch.ready <= ($urandom_range(1, 0) == 1);
      2: result_ch.ready <= ($urandom_range(9, 0) != 0);
      default: result_ch.ready <= ($urandom_range(15, 0) == 0);
    endcase
  end

  // Check each accepted result item
  always @(posedge clk) begin
    range_verdict_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.range_used     = result_ch.range_used;
      got.error_bound    = result_ch.error_bound;
      got.chosen_range   = result_ch.chosen_range;
      got.next_range     = result_ch.next_range;
      got.switched       = result_ch.switched;
      got.out_of_range   = result_ch.out_of_range;
      board.check_verdict(got);
    end
  end

  function automatic logic [WORD_W-1:0] pack_entry(int lo, int hi, int err);
    logic [11:0] lo_b;
    logic [11:0] hi_b;
    logic [7:0]  err_b;
    lo_b  = lo[11:0];
    hi_b  = hi[11:0];
    err_b = err[7:0];
    return {err_b, hi_b, lo_b};
  endfunction

  function automatic int clamp_reading(int r);
    if (r < READING_MIN) return READING_MIN;
    if (r > READING_MAX) return READING_MAX;
    return r;
  endfunction

  // Mostly sensible bands with small errors; now and then raw noise
  function automatic logic [WORD_W-1:0] random_entry();
    int centre;
    int half;
    int k;
    int err;
    if ($urandom_range(7, 0) == 0) return $urandom();
    centre = $urandom_range(4095, 0) - 2048;
    half   = $urandom_range(600, 10);
    k      = $urandom_range(9, 0);
    if (k < 7) err = $urandom_range(8, 0);
    else if (k == 7) err = int'(ERR_INVALID);
    else err = $urandom_range(255, 128);
    return pack_entry(clamp_reading(centre - half), clamp_reading(centre + half), err);
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    board.set_reg(idx, data);
  endtask

  // Hold the sender until every result item is back, then let the block settle
  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic send_reading(int r);
    logic signed [READING_W-1:0] rd;
    rd = r[READING_W-1:0];
    sample_ch.valid   <= 1'b1;
    sample_ch.reading <= rd;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    board.note_reading(rd);
  endtask

  // Send in bursts with random gaps between them
  task automatic feed_reading(int r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(12, 1);
      if (gap > 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(30, 1);
    end
    burst_left--;
    send_reading(r);
  endtask

  // Random walk with jumps, some of them onto a band edge
  function automatic int next_reading();
    int k;
    int i;
    int edge_pt;
    logic [WORD_W-1:0] w;
    k = $urandom_range(19, 0);
    if (k < 2) begin
      walk_pos = $urandom_range(4095, 0) - 2048;
    end else if (k < 5) begin
      i = $urandom_range(ENTRY_REGS - 1, 0);
      w = board.entry[i];
      if ($urandom_range(1, 0) == 1) edge_pt = int'($signed(w[11:0])) + int'(board.margin);
      else edge_pt = int'($signed(w[23:12])) - int'(board.margin);
      walk_pos = clamp_reading(edge_pt + $urandom_range(2, 0) - 1);
    end else begin
      walk_pos = clamp_reading(walk_pos + $urandom_range(64, 0) - 32);
    end
    return walk_pos;
  endfunction

  task automatic configure_phase(int p);
    logic [WORD_W-1:0] w;
    for (int i = 0; i < ENTRY_REGS; i++) begin
      w = random_entry();
      if (p == 4 && i == 0) w = '0;
      if (p == 4 && i == 1) w = '1;
      write_reg(reg_idx_t'(int'(REG_ENTRY_0) + i), w);
    end
    case (p)
      1: write_reg(REG_EDGE_MARGIN, 32'd0);
      2: write_reg(REG_EDGE_MARGIN, 32'd255);
      5: write_reg(REG_EDGE_MARGIN, $urandom_range(255, 0));
      default: write_reg(REG_EDGE_MARGIN, $urandom_range(40, 0));
    endcase
    case (p)
      1: write_reg(REG_HOLD_READINGS, 32'd0);
      3: write_reg(REG_HOLD_READINGS, 32'd255);
      6: write_reg(REG_HOLD_READINGS, $urandom_range(255, 0));
      default: write_reg(REG_HOLD_READINGS, $urandom_range(6, 0));
    endcase
    if (p == 7) write_reg(REG_UNUSED, $urandom());
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rst               <= 1'b1;
    sample_ch.valid   <= 1'b0;
    sample_ch.reading <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;
    burst_left = 0;
    walk_pos   = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed table: wide coarse band, tied twins, saturated error,
    // a band too narrow for the margin, immediate re-switching
    write_reg(REG_ENTRY_0, pack_entry(READING_MIN, 1000, 60));
    write_reg(REG_ENTRY_1, pack_entry(-400, 400, 5));
    write_reg(REG_ENTRY_2, pack_entry(-400, 400, 5));
    write_reg(REG_ENTRY_3, pack_entry(800, READING_MAX, 255));
    write_reg(REG_ENTRY_4, pack_entry(100, 110, 1));
    write_reg(REG_EDGE_MARGIN, 32'd16);
    write_reg(REG_HOLD_READINGS, 32'd0);
    write_reg(REG_UNUSED, 32'h1234_5678);
    cfg_ch.valid <= 1'b0;
    foreach (directed_readings[i]) feed_reading(directed_readings[i]);

    // Random phases, each under its own table and settings
    for (int p = 1; p <= RANDOM_PHASES; p++) begin
      drain();
      configure_phase(p);
      walk_pos = $urandom_range(4095, 0) - 2048;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2) drain();
        feed_reading(next_reading());
      end
    end

    drain();
    if (board.faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Give up long after the slowest correct run would have ended
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
